// ===== src/spi_pkg.sv =====
// Shared types and constants for the sensor packet identifier.
// Used by the capture, detection and top-level modules; no dependencies.

package spi_pkg;

    localparam int CNT_W                = 16;
    localparam int HDR_BYTES            = 12;
    localparam int HDR_IDX_W            = $clog2(HDR_BYTES);
    localparam int MAX_PACKET_BYTES_DEF = 65535;

    // Vendor codes.
    localparam logic [2:0] VENDOR_NONE = 3'd0;
    localparam logic [2:0] VENDOR_A    = 3'd1;
    localparam logic [2:0] VENDOR_B    = 3'd2;
    localparam logic [2:0] VENDOR_C    = 3'd3;
    localparam logic [2:0] VENDOR_D    = 3'd4;

    // Model codes.
    localparam logic [4:0] MODEL_NONE        = 5'd0;
    localparam logic [4:0] MODEL_A_40CH_10B  = 5'd1;
    localparam logic [4:0] MODEL_A_64CH_6B   = 5'd2;
    localparam logic [4:0] MODEL_A_64CH_4B   = 5'd3;
    localparam logic [4:0] MODEL_A_16CH_8B   = 5'd4;
    localparam logic [4:0] MODEL_A_32CH_8B   = 5'd5;
    localparam logic [4:0] MODEL_A_32CH_6B   = 5'd6;
    localparam logic [4:0] MODEL_A_128_LONG  = 5'd7;
    localparam logic [4:0] MODEL_A_128_MID   = 5'd8;
    localparam logic [4:0] MODEL_A_128_SHORT = 5'd9;
    localparam logic [4:0] MODEL_B_ID21      = 5'd10;
    localparam logic [4:0] MODEL_B_ID22_24   = 5'd11;
    localparam logic [4:0] MODEL_B_ID28      = 5'd12;
    localparam logic [4:0] MODEL_B_IDA1      = 5'd13;
    localparam logic [4:0] MODEL_C_LONG      = 5'd14;
    localparam logic [4:0] MODEL_C_SHORT     = 5'd15;
    localparam logic [4:0] MODEL_D_METHOD    = 5'd16;
    localparam logic [4:0] MODEL_D_CAN       = 5'd17;

    // Return mode codes.
    localparam logic [2:0] MODE_NONE           = 3'd0;
    localparam logic [2:0] MODE_SINGLE_FIRST   = 3'd1;
    localparam logic [2:0] MODE_SINGLE_STRONG  = 3'd2;
    localparam logic [2:0] MODE_SINGLE_LAST    = 3'd3;
    localparam logic [2:0] MODE_DUAL_LAST_STR  = 3'd4;
    localparam logic [2:0] MODE_DUAL_LAST_FRST = 3'd5;
    localparam logic [2:0] MODE_DUAL_FRST_STR  = 3'd6;
    localparam logic [2:0] MODE_DUAL           = 3'd7;

    // Confidence levels in percent.
    localparam logic [6:0] CONF_NONE = 7'd0;
    localparam logic [6:0] CONF_LOW  = 7'd70;
    localparam logic [6:0] CONF_MID  = 7'd80;
    localparam logic [6:0] CONF_HIGH = 7'd90;
    localparam logic [6:0] CONF_TOP  = 7'd95;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } pkt_t;

    typedef struct packed {
        logic       identified;
        logic [2:0] vendor;
        logic [4:0] model;
        logic [2:0] ret_mode;
        logic [6:0] confidence_pct;
    } ident_t;

    // Everything the detectors look at for the packet that just ended.
    typedef struct packed {
        logic [HDR_BYTES-1:0][7:0] hdr;
        logic [CNT_W-1:0]          size;
        logic [7:0]                prev_byte;
        logic [7:0]                cur_byte;
    } frame_t;

endpackage

// ===== src/spi_chan_if.sv =====
// Valid/ready channel carrying one payload item per handshake.
// The payload type is a parameter; no package dependency.

interface spi_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/spi_capture.sv =====
// Input register, header store, byte counter and previous-byte register.
// Depends on spi_pkg and spi_chan_if.

module spi_capture #(
    parameter int MAX_PACKET_BYTES = spi_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    spi_chan_if.sink        pkt,
    input  logic            slot_free,
    output logic            fire_last,
    output spi_pkg::frame_t frame
);
    import spi_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKET_BYTES);

    logic                      s1_valid_reg;
    logic [7:0]                s1_byte_reg;
    logic                      s1_last_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CNT_W-1:0]          size;
    logic [7:0]                prev_reg;
    logic [HDR_BYTES-1:0][7:0] hdr_reg;
    logic [HDR_BYTES-1:0][7:0] hdr_eff;
    logic                      advance;
    logic                      accept;
    logic                      in_header;

    // A final byte waits in the input register until the result slot is free.
    assign advance   = s1_valid_reg && (!s1_last_reg || slot_free);
    assign pkt.ready = !s1_valid_reg || advance;
    assign accept    = pkt.valid && pkt.ready;
    assign fire_last = advance && s1_last_reg;

    assign size       = (count_reg < MAX_CNT) ? count_reg + CNT_W'(1) : count_reg;
    assign count_next = s1_last_reg ? '0 : size;
    assign in_header  = count_reg < CNT_W'(HDR_BYTES);

    // The byte in flight is part of the header the detectors see.
    always_comb
    begin
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            hdr_eff[i] = (count_reg == CNT_W'(i)) ? s1_byte_reg : hdr_reg[i];
        end
    end

    assign frame.hdr       = hdr_eff;
    assign frame.size      = size;
    assign frame.prev_byte = prev_reg;
    assign frame.cur_byte  = s1_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= pkt.payload.data_byte;
            s1_last_reg <= pkt.payload.last;
        end
        if (advance)
        begin
            prev_reg <= s1_byte_reg;
            if (in_header)
            begin
                hdr_reg[count_reg[HDR_IDX_W-1:0]] <= s1_byte_reg;
            end
        end
    end

endmodule

// ===== src/spi_detect.sv =====
// Vendor detectors and the hint / priority selection of the final result.
// Depends on spi_pkg.

module spi_detect (
    input  spi_pkg::frame_t frame,
    input  logic [2:0]      hint,
    output spi_pkg::ident_t ident
);
    import spi_pkg::*;

    logic [7:0] h [HDR_BYTES];
    logic [CNT_W-1:0] sz;
    logic [31:0] w;

    ident_t id_a, id_b, id_c, id_d, id_sel;
    logic ok_a, ok_b, ok_c, ok_d, ok_sel;
    logic c_long, c_short, d_method, d_can;

    always_comb
    begin
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            h[i] = frame.hdr[i];
        end
    end

    assign sz = frame.size;
    assign w  = {h[0], h[1], h[2], h[3]};

    // Vendor A: 12-byte header with sync EE FF, lasers and blocks fields.
    always_comb
    begin
        ok_a = (sz >= CNT_W'(12)) && (h[0] == 8'hEE) && (h[1] == 8'hFF)
               && (h[6] != 8'd0) && (h[7] != 8'd0);
        id_a = '0;
        id_a.identified = 1'b1;
        id_a.vendor     = VENDOR_A;
        id_a.model      = MODEL_NONE;
        if (h[6] == 8'd40 && h[7] == 8'd10)      id_a.model = MODEL_A_40CH_10B;
        else if (h[6] == 8'd64 && h[7] == 8'd6)  id_a.model = MODEL_A_64CH_6B;
        else if (h[6] == 8'd64 && h[7] == 8'd4)  id_a.model = MODEL_A_64CH_4B;
        else if (h[6] == 8'd16 && h[7] == 8'd8)  id_a.model = MODEL_A_16CH_8B;
        else if (h[6] == 8'd32 && h[7] == 8'd8)  id_a.model = MODEL_A_32CH_8B;
        else if (h[6] == 8'd32 && h[7] == 8'd6)  id_a.model = MODEL_A_32CH_6B;
        else if (h[6] == 8'd128 && h[7] == 8'd2)
        begin
            if (sz == CNT_W'(1127))      id_a.model = MODEL_A_128_LONG;
            else if (sz == CNT_W'(1078)) id_a.model = MODEL_A_128_MID;
            else if (sz == CNT_W'(861))  id_a.model = MODEL_A_128_SHORT;
        end
        case (h[10])
            8'h33:   id_a.ret_mode = MODE_SINGLE_FIRST;
            8'h37:   id_a.ret_mode = MODE_SINGLE_STRONG;
            8'h38:   id_a.ret_mode = MODE_SINGLE_LAST;
            8'h39:   id_a.ret_mode = MODE_DUAL_LAST_STR;
            8'h3B:   id_a.ret_mode = MODE_DUAL_LAST_FRST;
            8'h3C:   id_a.ret_mode = MODE_DUAL_FRST_STR;
            8'h3E:   id_a.ret_mode = MODE_DUAL;
            default: id_a.ret_mode = MODE_NONE;
        endcase
        id_a.confidence_pct = (id_a.model == MODEL_NONE) ? CONF_LOW : CONF_HIGH;
    end

    // Vendor B: fixed 1206-byte packet with sync FF EE; the final byte is the
    // product id and the byte before it the return mode.
    always_comb
    begin
        ok_b = (sz == CNT_W'(1206)) && (h[0] == 8'hFF) && (h[1] == 8'hEE);
        id_b = '0;
        id_b.identified     = 1'b1;
        id_b.vendor         = VENDOR_B;
        id_b.confidence_pct = CONF_TOP;
        case (frame.cur_byte)
            8'h21:                id_b.model = MODEL_B_ID21;
            8'h22, 8'h23, 8'h24:  id_b.model = MODEL_B_ID22_24;
            8'h28:                id_b.model = MODEL_B_ID28;
            8'hA1:                id_b.model = MODEL_B_IDA1;
            default:              id_b.model = MODEL_NONE;
        endcase
        case (frame.prev_byte)
            8'd55:   id_b.ret_mode = MODE_SINGLE_STRONG;
            8'd56:   id_b.ret_mode = MODE_SINGLE_LAST;
            8'd57:   id_b.ret_mode = MODE_DUAL;
            default: id_b.ret_mode = MODE_NONE;
        endcase
    end

    // Vendor C: eight-byte magic, or its four-byte short form.
    always_comb
    begin
        c_long  = (sz >= CNT_W'(8)) && (h[0] == 8'h55) && (h[1] == 8'hAA)
                  && (h[2] == 8'h05) && (h[3] == 8'h0A) && (h[4] == 8'h5A)
                  && (h[5] == 8'hA5) && (h[6] == 8'h50) && (h[7] == 8'hA0);
        c_short = (sz >= CNT_W'(4)) && (h[0] == 8'h55) && (h[1] == 8'hAA)
                  && (h[2] == 8'h05) && (h[3] == 8'h5A);
        ok_c = c_long || c_short;
        id_c = '0;
        id_c.identified     = 1'b1;
        id_c.vendor         = VENDOR_C;
        id_c.model          = c_long ? MODEL_C_LONG : MODEL_C_SHORT;
        id_c.ret_mode       = MODE_NONE;
        id_c.confidence_pct = c_long ? CONF_TOP : CONF_MID;
    end

    // Vendor D: the first word is a method id or a CAN id, and each id allows
    // only exact packet lengths.
    always_comb
    begin
        d_method = 1'b0;
        if (w[31:16] == 16'd0)
        begin
            case (w[15:0])
                16'd390: d_method = (sz == CNT_W'(64));
                16'd336: d_method = (sz == CNT_W'(35336));
                16'd329: d_method = (sz == CNT_W'(9401)) || (sz == CNT_W'(37452));
                16'd380: d_method = (sz == CNT_W'(84));
                16'd396: d_method = (sz == CNT_W'(330));
                default: d_method = 1'b0;
            endcase
        end
        case (w)
            32'd900, 32'd1100, 32'd1200: d_can = (sz == CNT_W'(32));
            32'd901, 32'd1101, 32'd1201: d_can = (sz == CNT_W'(64));
            32'd800:                     d_can = (sz == CNT_W'(4));
            32'd700:                     d_can = (sz == CNT_W'(64));
            32'd53, 32'd600:             d_can = (sz == CNT_W'(8));
            32'd601:                     d_can = (sz == CNT_W'(16));
            default:                     d_can = 1'b0;
        endcase
        ok_d = (sz >= CNT_W'(4)) && (d_method || d_can);
        id_d = '0;
        id_d.identified     = 1'b1;
        id_d.vendor         = VENDOR_D;
        id_d.model          = d_method ? MODEL_D_METHOD : MODEL_D_CAN;
        id_d.ret_mode       = MODE_NONE;
        id_d.confidence_pct = CONF_TOP;
    end

    // A hint runs one detector and still names the hinted vendor on a miss.
    // Hint codes above the last vendor behave as no hint.
    always_comb
    begin
        id_sel = '0;
        ok_sel = 1'b0;
        ident  = '0;
        unique case (hint)
            VENDOR_A:
            begin
                id_sel = id_a;
                ok_sel = ok_a;
            end
            VENDOR_B:
            begin
                id_sel = id_b;
                ok_sel = ok_b;
            end
            VENDOR_C:
            begin
                id_sel = id_c;
                ok_sel = ok_c;
            end
            VENDOR_D:
            begin
                id_sel = id_d;
                ok_sel = ok_d;
            end
            default:
            begin
                id_sel = '0;
                ok_sel = 1'b0;
            end
        endcase
        if (hint >= VENDOR_A && hint <= VENDOR_D)
        begin
            if (ok_sel)
            begin
                ident = id_sel;
            end
            else
            begin
                ident.identified = 1'b1;
                ident.vendor     = hint;
            end
        end
        else if (ok_b) ident = id_b;
        else if (ok_a) ident = id_a;
        else if (ok_c) ident = id_c;
        else if (ok_d) ident = id_d;
    end

endmodule

// ===== src/sensor_packet_identifier_unit.sv =====
// Sensor packet identifier: takes one payload byte per cycle and, after the
// final byte, delivers one identification item.
// The final byte goes from the input register to the result register, waiting
// while the result slot is held. Throughput: one byte per cycle; a result
// waiting in the output register stalls only a later final byte.
// Reset clears the vendor hint, the byte counter and all valid flags; the
// header store needs no reset because it is written before it is read.

module sensor_packet_identifier_unit #(
    parameter int MAX_PACKET_BYTES = spi_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    spi_chan_if.sink   pkt,
    spi_chan_if.sink   cfg,
    spi_chan_if.source ident
);
    import spi_pkg::*;

    logic [2:0] vendor_hint_reg;
    logic       out_valid_reg;
    ident_t     out_data_reg;
    ident_t     result;
    frame_t     frame;
    logic       slot_free;
    logic       fire_last;

    assign slot_free = !out_valid_reg || ident.ready;

    spi_capture #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt),
        .slot_free (slot_free),
        .fire_last (fire_last),
        .frame     (frame)
    );

    spi_detect u_detect (
        .frame (frame),
        .hint  (vendor_hint_reg),
        .ident (result)
    );

    assign cfg.ready     = 1'b1;
    assign ident.valid   = out_valid_reg;
    assign ident.payload = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vendor_hint_reg <= VENDOR_NONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                vendor_hint_reg <= cfg.payload[2:0];
            end
            if (fire_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (ident.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire_last)
        begin
            out_data_reg <= result;
        end
    end

endmodule

// ===== tb/spi_ident_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the sensor packet identifier: predicts one identification
// per packet from the accepted bytes and checks results in order.
// Depends on spi_pkg for the item and result types and the code constants.

package spi_ident_tb_pkg;
    import spi_pkg::*;

    localparam logic [63:0] LONG_MAGIC  = 64'h55AA_050A_5AA5_50A0;
    localparam logic [31:0] SHORT_MAGIC = 32'h55AA_055A;

    class ident_checker;
        logic [2:0]  hint;
        logic [7:0]  hdr [HDR_BYTES];
        int unsigned count;
        logic [7:0]  prev_b;
        ident_t      pending_idents [$];
        int unsigned errors;
        int unsigned checked;

        function new();
            hint = VENDOR_NONE;
            count = 0;
            prev_b = '0;
            errors = 0;
            checked = 0;
            foreach (hdr[i])
            begin
                hdr[i] = '0;
            end
        endfunction

        function void set_hint(logic [2:0] v);
            hint = v;
        endfunction

        function ident_t make_ident(logic [2:0] v, logic [4:0] m, logic [2:0] r,
                                    logic [6:0] c);
            ident_t id;
            id.identified = 1'b1;
            id.vendor = v;
            id.model = m;
            id.ret_mode = r;
            id.confidence_pct = c;
            return id;
        endfunction

        function ident_t match_a(int unsigned size);
            logic [7:0] lasers;
            logic [7:0] blocks;
            logic [4:0] m;
            logic [2:0] r;
            if (size < 12 || hdr[0] != 8'hEE || hdr[1] != 8'hFF)
                return '0;
            lasers = hdr[6];
            blocks = hdr[7];
            if (lasers == 0 || blocks == 0)
                return '0;
            m = MODEL_NONE;
            if (lasers == 8'd40 && blocks == 8'd10)
                m = MODEL_A_40CH_10B;
            else if (lasers == 8'd64 && blocks == 8'd6)
                m = MODEL_A_64CH_6B;
            else if (lasers == 8'd64 && blocks == 8'd4)
                m = MODEL_A_64CH_4B;
            else if (lasers == 8'd16 && blocks == 8'd8)
                m = MODEL_A_16CH_8B;
            else if (lasers == 8'd32 && blocks == 8'd8)
                m = MODEL_A_32CH_8B;
            else if (lasers == 8'd32 && blocks == 8'd6)
                m = MODEL_A_32CH_6B;
            else if (lasers == 8'd128 && blocks == 8'd2)
            begin
                // The three 128-channel variants differ only in packet length.
                if (size == 1127)
                    m = MODEL_A_128_LONG;
                else if (size == 1078)
                    m = MODEL_A_128_MID;
                else if (size == 861)
                    m = MODEL_A_128_SHORT;
            end
            case (hdr[10])
                8'h33:   r = MODE_SINGLE_FIRST;
                8'h37:   r = MODE_SINGLE_STRONG;
                8'h38:   r = MODE_SINGLE_LAST;
                8'h39:   r = MODE_DUAL_LAST_STR;
                8'h3B:   r = MODE_DUAL_LAST_FRST;
                8'h3C:   r = MODE_DUAL_FRST_STR;
                8'h3E:   r = MODE_DUAL;
                default: r = MODE_NONE;
            endcase
            return make_ident(VENDOR_A, m, r, (m == MODEL_NONE) ? CONF_LOW : CONF_HIGH);
        endfunction

        function ident_t match_b(int unsigned size, logic [7:0] ret_b, logic [7:0] prod_b);
            logic [4:0] m;
            logic [2:0] r;
            if (size != 1206 || hdr[0] != 8'hFF || hdr[1] != 8'hEE)
                return '0;
            case (prod_b)
                8'h21:               m = MODEL_B_ID21;
                8'h22, 8'h23, 8'h24: m = MODEL_B_ID22_24;
                8'h28:               m = MODEL_B_ID28;
                8'hA1:               m = MODEL_B_IDA1;
                default:             m = MODEL_NONE;
            endcase
            case (ret_b)
                8'd55:   r = MODE_SINGLE_STRONG;
                8'd56:   r = MODE_SINGLE_LAST;
                8'd57:   r = MODE_DUAL;
                default: r = MODE_NONE;
            endcase
            return make_ident(VENDOR_B, m, r, CONF_TOP);
        endfunction

        function ident_t match_c(int unsigned size);
            if (size >= 8 && {hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5], hdr[6], hdr[7]}
                == LONG_MAGIC)
                return make_ident(VENDOR_C, MODEL_C_LONG, MODE_NONE, CONF_TOP);
            if (size >= 4 && {hdr[0], hdr[1], hdr[2], hdr[3]} == SHORT_MAGIC)
                return make_ident(VENDOR_C, MODEL_C_SHORT, MODE_NONE, CONF_MID);
            return '0;
        endfunction

        function bit method_fits(logic [15:0] method, int unsigned size);
            case (method)
                16'd390: return size == 64;
                16'd336: return size == 35336;
                16'd329: return size == 9401 || size == 37452;
                16'd380: return size == 84;
                16'd396: return size == 330;
                default: return 1'b0;
            endcase
        endfunction

        function bit can_fits(logic [31:0] id, int unsigned size);
            case (id)
                32'd900, 32'd1100, 32'd1200: return size == 32;
                32'd901, 32'd1101, 32'd1201: return size == 64;
                32'd800:                     return size == 4;
                32'd700:                     return size == 64;
                32'd53:                      return size == 8;
                32'd600:                     return size == 8;
                32'd601:                     return size == 16;
                default:                     return 1'b0;
            endcase
        endfunction

        function ident_t match_d(int unsigned size);
            logic [31:0] w;
            if (size < 4)
                return '0;
            w = {hdr[0], hdr[1], hdr[2], hdr[3]};
            if (w[31:16] == 16'd0 && method_fits(w[15:0], size))
                return make_ident(VENDOR_D, MODEL_D_METHOD, MODE_NONE, CONF_TOP);
            if (can_fits(w, size))
                return make_ident(VENDOR_D, MODEL_D_CAN, MODE_NONE, CONF_TOP);
            return '0;
        endfunction

        function ident_t identify_packet(int unsigned size, logic [7:0] ret_b,
                                         logic [7:0] prod_b);
            ident_t id;
            case (hint)
                VENDOR_A: id = match_a(size);
                VENDOR_B: id = match_b(size, ret_b, prod_b);
                VENDOR_C: id = match_c(size);
                VENDOR_D: id = match_d(size);
                default:
                begin
                    // Without a usable hint the detectors run in a fixed order.
                    id = match_b(size, ret_b, prod_b);
                    if (!id.identified)
                        id = match_a(size);
                    if (!id.identified)
                        id = match_c(size);
                    if (!id.identified)
                        id = match_d(size);
                end
            endcase
            if (hint >= VENDOR_A && hint <= VENDOR_D && !id.identified)
                id = make_ident(hint, MODEL_NONE, MODE_NONE, CONF_NONE);
            return id;
        endfunction

        function void note_item(pkt_t item);
            logic [7:0]  ret_b;
            int unsigned size;
            ret_b = prev_b;
            if (count < HDR_BYTES)
                hdr[count] = item.data_byte;
            if (count < MAX_PACKET_BYTES_DEF)
                count++;
            prev_b = item.data_byte;
            if (item.last)
            begin
                size = count;
                count = 0;
                pending_idents.push_back(identify_packet(size, ret_b, item.data_byte));
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got_v);
            if (want != got_v)
            begin
                $display("%0t: %s differs, expected %0d, actual %0d", $time, name, want, got_v);
                errors++;
            end
        endfunction

        function void check_result(ident_t got);
            ident_t want;
            if (pending_idents.size() == 0)
            begin
                $display("%0t: identification with nothing pending, actual vendor %0d model %0d",
                         $time, got.vendor, got.model);
                errors++;
                return;
            end
            want = pending_idents.pop_front();
            checked++;
            compare_field("identified", want.identified, got.identified);
            compare_field("vendor", want.vendor, got.vendor);
            compare_field("model", want.model, got.model);
            compare_field("ret_mode", want.ret_mode, got.ret_mode);
            compare_field("confidence_pct", want.confidence_pct, got.confidence_pct);
        endfunction
    endclass

endpackage

// ===== tb/sensor_packet_identifier_unit_test.sv =====
`timescale 1ns / 1ps
// Top-level testbench for the sensor packet identifier: directed packets without a
// hint, random packets under all vendor hints, with idle and stall phases on both sides.
// Depends on spi_pkg, spi_chan_if, spi_ident_tb_pkg and the block itself.

module sensor_packet_identifier_unit_test;
    import spi_pkg::*;
    import spi_ident_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES  = 20;
    localparam int unsigned PHASE_BYTES  = 60;
    localparam int          PHASES       = 8;
    localparam logic [2:0]  HINT_BEYOND  = 3'd5;
    localparam logic [2:0]  HINT_MAX     = 3'd7;

    logic clk;
    logic rst_n;

    spi_chan_if #(.T(pkt_t))       pkt_ch ();
    spi_chan_if #(.T(logic [2:0])) cfg_ch ();
    spi_chan_if #(.T(ident_t))     ident_ch ();

    sensor_packet_identifier_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_ch),
        .cfg   (cfg_ch),
        .ident (ident_ch)
    );

    ident_checker ident_sb = new();

    int          send_idle_pct;
    int          recv_stall_pct;
    int unsigned cycles;
    int unsigned bytes_sent;
    int unsigned packets_sent;
    logic [7:0]  pkt_bytes [$];

    logic [7:0]  a_lasers [7]     = '{8'd40, 8'd64, 8'd64, 8'd16, 8'd32, 8'd32, 8'd128};
    logic [7:0]  a_blocks [7]     = '{8'd10, 8'd6, 8'd4, 8'd8, 8'd8, 8'd6, 8'd2};
    logic [7:0]  a_mode_bytes [7] = '{8'h33, 8'h37, 8'h38, 8'h39, 8'h3B, 8'h3C, 8'h3E};
    logic [7:0]  b_prods [6]      = '{8'h21, 8'h22, 8'h23, 8'h24, 8'h28, 8'hA1};
    int unsigned d_methods [2]    = '{390, 380};
    int unsigned d_method_sz [2]  = '{64, 84};
    int unsigned d_can_ids [11]   = '{900, 1100, 1200, 901, 1101, 1201, 800, 700, 53, 600, 601};
    int unsigned d_can_sz [11]    = '{32, 32, 32, 64, 64, 64, 4, 64, 8, 8, 16};
    logic [2:0]  phase_hint [PHASES] = '{VENDOR_A, VENDOR_D, VENDOR_B, VENDOR_C,
                                         HINT_MAX, VENDOR_NONE, HINT_BEYOND, VENDOR_NONE};

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("sensor_packet_identifier_unit: mismatch");
        $finish;
    end

    // Result side: check on each accepted item, then choose the next ready.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && ident_ch.valid && ident_ch.ready)
                ident_sb.check_result(ident_ch.payload);
            ident_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    function automatic void fill_packet(int unsigned size);
        pkt_bytes.delete();
        repeat (size) pkt_bytes.push_back(8'($urandom_range(255, 0)));
    endfunction

    function automatic void set_byte(int unsigned at, logic [7:0] value);
        if (at < pkt_bytes.size())
            pkt_bytes[at] = value;
    endfunction

    function automatic void put_word(int unsigned at, logic [31:0] w);
        set_byte(at, w[31:24]);
        set_byte(at + 1, w[23:16]);
        set_byte(at + 2, w[15:8]);
        set_byte(at + 3, w[7:0]);
    endfunction

    function automatic void build_a(int unsigned size, logic [7:0] lasers, logic [7:0] blocks,
                                    logic [7:0] mode_b);
        fill_packet(size);
        set_byte(0, 8'hEE);
        set_byte(1, 8'hFF);
        set_byte(6, lasers);
        set_byte(7, blocks);
        set_byte(10, mode_b);
    endfunction

    function automatic void build_b(int unsigned size, logic [7:0] ret_b, logic [7:0] prod_b);
        fill_packet(size);
        set_byte(0, 8'hFF);
        set_byte(1, 8'hEE);
        set_byte(size - 2, ret_b);
        set_byte(size - 1, prod_b);
    endfunction

    function automatic void build_c(int unsigned size, bit long_form);
        fill_packet(size);
        if (long_form)
        begin
            put_word(0, LONG_MAGIC[63:32]);
            put_word(4, LONG_MAGIC[31:0]);
        end
        else
            put_word(0, SHORT_MAGIC);
    endfunction

    function automatic void build_d(int unsigned size, logic [31:0] w);
        fill_packet(size);
        put_word(0, w);
    endfunction

    task automatic send_packet();
        pkt_t item;
        for (int i = 0; i < pkt_bytes.size(); i++)
        begin
            while ($urandom_range(99, 0) < send_idle_pct)
            begin
                pkt_ch.valid <= 1'b0;
                @(posedge clk);
            end
            item.data_byte = pkt_bytes[i];
            item.last = (i == pkt_bytes.size() - 1);
            pkt_ch.valid <= 1'b1;
            pkt_ch.payload <= item;
            do @(posedge clk); while (!pkt_ch.ready);
            ident_sb.note_item(item);
            bytes_sent++;
        end
        packets_sent++;
    endtask

    task automatic drain();
        pkt_ch.valid <= 1'b0;
        do @(posedge clk); while (ident_sb.pending_idents.size() != 0);
    endtask

    task automatic write_hint(logic [2:0] h);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= h;
        do @(posedge clk); while (!cfg_ch.ready);
        ident_sb.set_hint(h);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_packet();
        int unsigned kind;
        int unsigned size;
        int unsigned k;
        logic [7:0]  lasers;
        logic [7:0]  blocks;
        logic [7:0]  mode_b;
        logic [31:0] w;
        kind = $urandom_range(99, 0);
        if (kind < 20)
        begin
            k = $urandom_range(6, 0);
            size = $urandom_range(40, 11);
            lasers = a_lasers[k];
            blocks = a_blocks[k];
            if ($urandom_range(3, 0) == 0)
            begin
                lasers = $urandom_range(1, 0) ? 8'd0 : 8'($urandom_range(255, 0));
                blocks = $urandom_range(1, 0) ? 8'd0 : 8'($urandom_range(255, 0));
            end
            mode_b = ($urandom_range(9, 0) < 7) ? a_mode_bytes[$urandom_range(6, 0)]
                                                 : 8'($urandom_range(255, 0));
            build_a(size, lasers, blocks, mode_b);
            if ($urandom_range(9, 0) == 0)
                set_byte($urandom_range(1, 0), 8'($urandom_range(255, 0)));
        end
        else if (kind < 28)
        begin
            // Short packets with the sync bytes never reach the fixed length.
            size = $urandom_range(40, 2);
            build_b(size,
                    ($urandom_range(3, 0) != 0) ? 8'($urandom_range(57, 55))
                                                : 8'($urandom_range(255, 0)),
                    ($urandom_range(3, 0) != 0) ? b_prods[$urandom_range(5, 0)]
                                                : 8'($urandom_range(255, 0)));
        end
        else if (kind < 46)
        begin
            k = $urandom_range(1, 0);
            size = (k != 0) ? $urandom_range(24, 8) : $urandom_range(24, 4);
            if ($urandom_range(9, 0) == 0)
                size = $urandom_range(7, 1);
            build_c(size, k != 0);
            if ($urandom_range(6, 0) == 0)
                set_byte($urandom_range(7, 0), 8'($urandom_range(255, 0)));
        end
        else if (kind < 72)
        begin
            if ($urandom_range(1, 0) != 0)
            begin
                k = $urandom_range(1, 0);
                w = d_methods[k];
                size = d_method_sz[k];
            end
            else
            begin
                k = $urandom_range(10, 0);
                w = d_can_ids[k];
                size = d_can_sz[k];
            end
            if ($urandom_range(4, 0) == 0)
                size = $urandom_range(64, 1);
            if ($urandom_range(9, 0) == 0)
                w[31:16] = 16'($urandom_range(65535, 0));
            build_d(size, w);
        end
        else
            fill_packet(($urandom_range(4, 0) == 0) ? $urandom_range(3, 1)
                                                    : $urandom_range(24, 1));
        send_packet();
    endtask

    initial
    begin
        int unsigned start_bytes;
        rst_n = 1'b0;
        pkt_ch.valid = 1'b0;
        pkt_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        ident_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        bytes_sent = 0;
        packets_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_hint(VENDOR_NONE);

        // Directed packets: minimal sizes, the short forms of each vendor and
        // length edges around the header checks.
        fill_packet(1);
        set_byte(0, 8'h00);
        send_packet();
        fill_packet(1);
        set_byte(0, 8'hFF);
        send_packet();
        build_a(12, 8'd40, 8'd10, 8'h33);
        send_packet();
        build_a(20, 8'd0, 8'd6, 8'h3B);
        send_packet();
        build_a(11, 8'd64, 8'd6, 8'h3C);
        send_packet();
        build_b(20, 8'd55, 8'h21);
        send_packet();
        build_c(8, 1'b1);
        send_packet();
        build_c(4, 1'b0);
        send_packet();
        // Too short to reach the fourth magic byte; older header bytes must not count.
        build_c(3, 1'b0);
        send_packet();
        build_d(64, 32'd390);
        send_packet();
        build_d(4, 32'd800);
        send_packet();
        build_d(8, 32'd53);
        send_packet();
        build_d(16, 32'd601);
        send_packet();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            write_hint(phase_hint[ph]);
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 66;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 66;
                end
                default:
                begin
                    send_idle_pct = 25;
                    recv_stall_pct = 25;
                end
            endcase
            start_bytes = bytes_sent;
            while (bytes_sent - start_bytes < PHASE_BYTES)
            begin
                random_packet();
                if ($urandom_range(19, 0) == 0)
                    drain();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d packets (%0d bytes), checked %0d identifications", packets_sent,
                 bytes_sent, ident_sb.checked);
        $display("Ran each vendor hint and out-of-range hints, with sender gaps and stalls");
        if (ident_sb.errors == 0 && ident_sb.pending_idents.size() == 0)
            $display("sensor_packet_identifier_unit: match");
        else
            $display("sensor_packet_identifier_unit: mismatch");
        $finish;
    end

endmodule
